// ===== rtl/core/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants for the substring replace unit
// Transaction structs, register indexes and default size limits.
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int DEFAULT_MAX_SEARCH  = 8;
   localparam int DEFAULT_MAX_REPLACE = 8;

   localparam int CFG_W     = 64;
   localparam int LEN_W     = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_PATTERN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_LENGTH      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_TEXT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_LENGTH = 3'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } ssr_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_has_byte;
      logic       out_last;
   } ssr_rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] search_pattern;
      logic [LEN_W-1:0] search_length;
      logic [CFG_W-1:0] replacement_text;
      logic [LEN_W-1:0] replacement_length;
   } ssr_cfg_type;

   // Control from the window stage to the result sequencer
   typedef struct packed {
      logic load;
      logic marker;
      logic last;
   } ssr_load_type;

endpackage

// ===== rtl/core/ssr_csr.sv =====
// ----------------------------------------------------------------------------
// ssr_csr: configuration registers
// Holds the search pattern, replacement text and their lengths.
// ----------------------------------------------------------------------------
module ssr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssr_pkg::CFG_W-1:0]       csr_data,
   output ssr_pkg::ssr_cfg_type            cfg
);
   import ssr_pkg::*;

   ssr_cfg_type cfg_ff;
   logic        write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (write) begin
         case (csr_index)
            CSR_SEARCH_PATTERN: begin
               cfg_ff.search_pattern <= csr_data;
            end
            CSR_SEARCH_LENGTH: begin
               cfg_ff.search_length <= csr_data[LEN_W-1:0];
            end
            CSR_REPLACEMENT_TEXT: begin
               cfg_ff.replacement_text <= csr_data;
            end
            CSR_REPLACEMENT_LENGTH: begin
               cfg_ff.replacement_length <= csr_data[LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/ssr_window.sv =====
// ----------------------------------------------------------------------------
// ssr_window: match window and burst builder
// Appends each accepted byte, tests for a match and builds the result burst.
// ----------------------------------------------------------------------------
module ssr_window #(
   parameter int MAX_SEARCH  = ssr_pkg::DEFAULT_MAX_SEARCH,
   parameter int MAX_REPLACE = ssr_pkg::DEFAULT_MAX_REPLACE,
   localparam int BURST      = (MAX_SEARCH > MAX_REPLACE) ? MAX_SEARCH : MAX_REPLACE,
   localparam int BURST_W    = BURST * 8,
   localparam int CNT_W      = $clog2(BURST + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ssr_pkg::ssr_cfg_type   cfg,
   input  logic                   accept,
   input  ssr_pkg::ssr_req_type   req_data,
   output ssr_pkg::ssr_load_type  load_ctl,
   output logic [CNT_W-1:0]       burst_count,
   output logic [BURST_W-1:0]     burst_bytes
);
   import ssr_pkg::*;

   localparam int WIN_W  = MAX_SEARCH * 8;
   localparam int REP_W  = MAX_REPLACE * 8;
   localparam int FILL_W = $clog2(MAX_SEARCH + 1);

   logic [WIN_W-1:0]  win_ff, win_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic [FILL_W-1:0] slen;
   logic [CNT_W-1:0]  rlen;
   logic [FILL_W-1:0] fill_app;
   logic [WIN_W-1:0]  win_app;
   logic [FILL_W-1:0] pop;
   logic              match_all;
   logic              hit;
   logic [CNT_W-1:0]  count;
   logic              marker;

   always_comb begin
      slen = (cfg.search_length > LEN_W'(MAX_SEARCH)) ? FILL_W'(MAX_SEARCH)
                                                      : FILL_W'(cfg.search_length);
      rlen = (cfg.replacement_length > LEN_W'(MAX_REPLACE)) ? CNT_W'(MAX_REPLACE)
                                                            : CNT_W'(cfg.replacement_length);
      fill_app = fill_ff + FILL_W'(1);
      // bytes above the fill level are always zero, so an OR places the new byte
      win_app  = win_ff | (WIN_W'(req_data.in_byte) << {fill_app - FILL_W'(1), 3'b000});

      match_all = 1'b1;
      for (int i = 0; i < MAX_SEARCH; i++) begin
         if (FILL_W'(i) < slen && win_app[i*8 +: 8] != cfg.search_pattern[i*8 +: 8]) begin
            match_all = 1'b0;
         end
      end
      hit = (slen != '0) && (fill_app == slen) && match_all;

      // drain down to one below the pattern length; drain all on last or pass through
      if (req_data.in_last || slen == '0) begin
         pop = fill_app;
      end else if (fill_app >= slen) begin
         pop = fill_app - slen + FILL_W'(1);
      end else begin
         pop = '0;
      end

      count  = hit ? rlen : CNT_W'(pop);
      marker = req_data.in_last && (count == '0);
      if (marker) begin
         count = CNT_W'(1);
      end

      if (hit || req_data.in_last) begin
         win_in  = '0;
         fill_in = '0;
      end else begin
         win_in  = win_app >> {pop, 3'b000};
         fill_in = fill_app - pop;
      end
   end

   assign burst_bytes     = hit ? BURST_W'(cfg.replacement_text[REP_W-1:0]) : BURST_W'(win_app);
   assign burst_count     = count;
   assign load_ctl.load   = accept && (count != '0);
   assign load_ctl.marker = marker;
   assign load_ctl.last   = req_data.in_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         win_ff  <= win_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== rtl/core/ssr_burst.sv =====
// ----------------------------------------------------------------------------
// ssr_burst: result register and sequencer
// Holds one item's result burst and presents it one byte per transaction.
// ----------------------------------------------------------------------------
module ssr_burst #(
   parameter int MAX_SEARCH  = ssr_pkg::DEFAULT_MAX_SEARCH,
   parameter int MAX_REPLACE = ssr_pkg::DEFAULT_MAX_REPLACE,
   localparam int BURST      = (MAX_SEARCH > MAX_REPLACE) ? MAX_SEARCH : MAX_REPLACE,
   localparam int BURST_W    = BURST * 8,
   localparam int CNT_W      = $clog2(BURST + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ssr_pkg::ssr_load_type  load_ctl,
   input  logic [CNT_W-1:0]       burst_count,
   input  logic [BURST_W-1:0]     burst_bytes,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ssr_pkg::ssr_rsp_type   rsp_data
);
   import ssr_pkg::*;

   localparam int IDX_W = (BURST > 1) ? $clog2(BURST) : 1;

   logic               valid_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [BURST_W-1:0] bytes_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               marker_ff;
   logic               last_ff;
   logic               last_beat;
   logic               fire;

   assign last_beat = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign fire      = valid_ff && !rsp_stall;
   assign free      = !valid_ff || (last_beat && !rsp_stall);

   assign rsp_valid             = valid_ff;
   assign rsp_data.out_byte     = marker_ff ? 8'd0 : bytes_ff[{idx_ff, 3'b000} +: 8];
   assign rsp_data.out_has_byte = !marker_ff;
   assign rsp_data.out_last     = last_ff && last_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load_ctl.load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (fire && last_beat) begin
         valid_ff <= 1'b0;
      end else if (fire) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load_ctl.load) begin
         bytes_ff  <= burst_bytes;
         count_ff  <= burst_count;
         marker_ff <= load_ctl.marker;
         last_ff   <= load_ctl.last;
      end
   end

endmodule

// ===== rtl/core/streaming_substring_replace_unit.sv =====
// ----------------------------------------------------------------------------
// streaming_substring_replace_unit: streaming find and replace on a byte stream
// Replaces every leftmost, non-overlapping occurrence of a pattern.
// ----------------------------------------------------------------------------
// Each input transaction is matched against the window in the cycle it is
// accepted, and its results (zero to max(MAX_SEARCH, MAX_REPLACE) bytes, or one
// empty end marker on a last byte) load into the result register, first
// result showing in the next cycle. While rsp_stall is low, the result register
// sends one byte per cycle, so an item producing more than one result keeps
// req_stall high until its last result is sent, and items producing zero or
// one result flow at one per cycle. Program the registers only while the unit is idle.
module streaming_substring_replace_unit #(
   parameter int MAX_SEARCH  = ssr_pkg::DEFAULT_MAX_SEARCH,
   parameter int MAX_REPLACE = ssr_pkg::DEFAULT_MAX_REPLACE
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ssr_pkg::ssr_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ssr_pkg::ssr_rsp_type            rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssr_pkg::CFG_W-1:0]       csr_data
);
   import ssr_pkg::*;

   localparam int BURST   = (MAX_SEARCH > MAX_REPLACE) ? MAX_SEARCH : MAX_REPLACE;
   localparam int BURST_W = BURST * 8;
   localparam int CNT_W   = $clog2(BURST + 1);

   ssr_cfg_type        cfg;
   ssr_load_type       load_ctl;
   logic [CNT_W-1:0]   burst_count;
   logic [BURST_W-1:0] burst_bytes;
   logic               free;
   logic               accept;

   assign req_stall = !free;
   assign accept    = req_valid && !req_stall;

   ssr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ssr_window #(
      .MAX_SEARCH  (MAX_SEARCH),
      .MAX_REPLACE (MAX_REPLACE)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .accept      (accept),
      .req_data    (req_data),
      .load_ctl    (load_ctl),
      .burst_count (burst_count),
      .burst_bytes (burst_bytes)
   );

   ssr_burst #(
      .MAX_SEARCH  (MAX_SEARCH),
      .MAX_REPLACE (MAX_REPLACE)
   ) u_burst (
      .clock       (clock),
      .reset       (reset),
      .load_ctl    (load_ctl),
      .burst_count (burst_count),
      .burst_bytes (burst_bytes),
      .free        (free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   // input only backs up behind a pending result
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // an empty end marker always closes the stream
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_has_byte |-> rsp_data.out_last)
      else $error("empty marker without last flag");

   // a newly accepted transaction with results shows a result next cycle
   assert property (@(posedge clock) disable iff (reset) load_ctl.load |=> rsp_valid)
      else $error("loaded burst not presented");
`endif

endmodule

// ===== bench/streaming_substring_replace_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streaming_substring_replace_unit_tb: self-checking bench for substring replace
// Drives byte streams against several pattern and replacement settings. A
// scoreboard predicts the replaced stream and checks every result transaction.
// ----------------------------------------------------------------------------
module streaming_substring_replace_unit_tb;
   import ssr_pkg::*;

   localparam int MAX_SEARCH       = DEFAULT_MAX_SEARCH;
   localparam int MAX_REPLACE      = DEFAULT_MAX_REPLACE;
   localparam int MAX_RESULTS      = (MAX_SEARCH > MAX_REPLACE) ? MAX_SEARCH : MAX_REPLACE;
   localparam int RANDOM_ITEMS     = 440;
   localparam int PHASE_ITEMS      = 40;
   localparam int SETTLE_CYCLES    = 4;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int REPORT_LIMIT     = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd5;

   class ssr_scoreboard;
      logic [CFG_W-1:0] search_pattern;
      logic [LEN_W-1:0] search_length;
      logic [CFG_W-1:0] replacement_text;
      logic [LEN_W-1:0] replacement_length;
      logic [7:0]       window [MAX_SEARCH];
      int unsigned      fill;
      ssr_rsp_type      expected_out [$];
      int unsigned      error_count;
      int unsigned      checked_count;
      int unsigned      match_count;

      function new();
         search_pattern     = '0;
         search_length      = '0;
         replacement_text   = '0;
         replacement_length = '0;
         error_count        = 0;
         checked_count      = 0;
         match_count        = 0;
         clear_window();
      endfunction

      function void clear_window();
         fill = 0;
         foreach (window[i]) window[i] = 8'h00;
      endfunction

      function logic [7:0] pop_oldest();
         logic [7:0] oldest;
         oldest = window[0];
         for (int i = 1; i < MAX_SEARCH; i++) window[i-1] = window[i];
         window[MAX_SEARCH-1] = 8'h00;
         if (fill > 0) fill--;
         return oldest;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
         case (index)
            CSR_SEARCH_PATTERN:     search_pattern     = value;
            CSR_SEARCH_LENGTH:      search_length      = value[LEN_W-1:0];
            CSR_REPLACEMENT_TEXT:   replacement_text   = value;
            CSR_REPLACEMENT_LENGTH: replacement_length = value[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // Append one byte to the window and queue the bytes it releases
      function void predict_replacement(ssr_req_type req);
         ssr_rsp_type produced [MAX_RESULTS];
         int unsigned slen;
         int unsigned rlen;
         int unsigned n;
         bit          hit;
         slen = (search_length > MAX_SEARCH) ? MAX_SEARCH : search_length;
         rlen = (replacement_length > MAX_REPLACE) ? MAX_REPLACE : replacement_length;
         n = 0;
         if (fill >= MAX_SEARCH) void'(pop_oldest());
         window[fill] = req.in_byte;
         fill++;
         if (slen > 0 && fill == slen) begin
            hit = 1'b1;
            for (int i = 0; i < slen; i++) begin
               if (window[i] != search_pattern[8*i +: 8]) hit = 1'b0;
            end
            if (hit) begin
               match_count++;
               for (int i = 0; i < rlen; i++) begin
                  produced[n] = '{replacement_text[8*i +: 8], 1'b1, 1'b0};
                  n++;
               end
               clear_window();
            end
         end
         // a window longer than the pattern (length shrunk) drains without a compare
         while (fill > 0 && fill >= slen && n < MAX_SEARCH) begin
            produced[n] = '{pop_oldest(), 1'b1, 1'b0};
            n++;
         end
         if (req.in_last) begin
            while (fill > 0 && n < MAX_SEARCH) begin
               produced[n] = '{pop_oldest(), 1'b1, 1'b0};
               n++;
            end
            clear_window();
            if (n == 0) begin
               produced[0] = '{8'h00, 1'b0, 1'b1};
               n = 1;
            end else begin
               produced[n-1].out_last = 1'b1;
            end
         end
         for (int i = 0; i < n; i++) expected_out.push_back(produced[i]);
      endfunction

      function void check_output(ssr_rsp_type got);
         ssr_rsp_type want;
         if (expected_out.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: unexpected result byte %02h has %0b last %0b", $time,
                        got.out_byte, got.out_has_byte, got.out_last);
            return;
         end
         want = expected_out.pop_front();
         checked_count++;
         if (got.out_byte !== want.out_byte || got.out_has_byte !== want.out_has_byte ||
             got.out_last !== want.out_last) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: result %0d expected byte %02h has %0b last %0b, got %02h %0b %0b",
                        $time, checked_count, want.out_byte, want.out_has_byte, want.out_last,
                        got.out_byte, got.out_has_byte, got.out_last);
         end
      endfunction

      function int unsigned pending();
         return expected_out.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   ssr_req_type          req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   ssr_rsp_type          rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;

   ssr_scoreboard sb = new();

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned items_sent     = 0;
   int unsigned csr_writes     = 0;
   int unsigned cycle_count    = 0;

   streaming_substring_replace_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.predict_replacement(req_data);
         if (rsp_valid && !rsp_stall) sb.check_output(rsp_data);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("[streaming_substring_replace_unit] ERROR");
      $finish;
   end

   task automatic send_byte(logic [7:0] value, logic last);
      // draw each idle slot separately so the idle share matches the percentage
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: value, in_last: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Hold the sender off until every expected result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(index, value);
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Length registers take the low nibble; fill the upper bits with junk
   task automatic program_settings(logic [CFG_W-1:0] pattern, logic [LEN_W-1:0] slen,
                                   logic [CFG_W-1:0] text, logic [LEN_W-1:0] rlen);
      logic [CFG_W-1:0] junk;
      junk = {$urandom, $urandom};
      csr_write(CSR_SEARCH_PATTERN, pattern);
      csr_write(CSR_SEARCH_LENGTH, {junk[CFG_W-1:LEN_W], slen});
      csr_write(CSR_REPLACEMENT_TEXT, text);
      junk = {$urandom, $urandom};
      csr_write(CSR_REPLACEMENT_LENGTH, {junk[CFG_W-1:LEN_W], rlen});
      if ($urandom_range(2) == 0) csr_write(CSR_UNUSED_INDEX, {$urandom, $urandom});
   endtask

   logic [7:0]       alpha [4];
   logic [7:0]       stream [$];
   logic [CFG_W-1:0] pattern;
   logic [LEN_W-1:0] slen;
   logic [LEN_W-1:0] rlen;
   int unsigned      slen_eff;
   int unsigned      directed_items;
   int unsigned      random_sent;
   int unsigned      phase;
   int unsigned      phase_items;
   int unsigned      chunks;
   int unsigned      pick;
   int unsigned      prefix;
   bit               noise;
   bit               pressured;

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pass through with registers at reset
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain();

      // "ab" -> "XYZ": miss, match, miss, match on the last byte
      program_settings(64'h6261, 4'd2, 64'h5A5958, 4'd3);
      send_byte(8'h78, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b1);
      drain();

      // delete matches: deleted last match leaves only the empty end marker
      csr_write(CSR_REPLACEMENT_LENGTH, 64'h0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b1);
      send_byte(8'h61, 1'b1);
      drain();

      // over-limit lengths saturate to a full window and a full replacement
      program_settings(64'hFFEE_DDCC_BBAA_9988, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd12);
      for (int i = 0; i < MAX_SEARCH; i++) send_byte(8'h88 + 8'h11 * i, i == MAX_SEARCH - 1);
      for (int i = 0; i < 4; i++) send_byte(8'h71, 1'b0);
      drain();

      // shrink the pattern with bytes still windowed
      csr_write(CSR_SEARCH_LENGTH, 64'd2);
      send_byte(8'h72, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain();
      directed_items = items_sent;

      phase = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent < RANDOM_ITEMS / 3) begin
            send_idle_pct  = 36;
            recv_stall_pct = 54;
         end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct  = 54;
            recv_stall_pct = 36;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end

         if (phase % 2 == 1) begin
            alpha[0] = 8'h00;
            alpha[1] = 8'hFF;
         end else begin
            alpha[0] = $urandom_range(255);
            alpha[1] = $urandom_range(255);
         end
         alpha[2] = $urandom_range(255);
         alpha[3] = $urandom_range(255);
         for (int i = 0; i < MAX_SEARCH; i++) pattern[8*i +: 8] = alpha[$urandom_range(3)];
         case (phase % 6)
            0: begin
               slen = 4'd8;
               rlen = 4'd8;
            end
            1: begin
               slen = 4'd1;
               rlen = 4'd0;
            end
            2: begin
               slen = 4'd0;
               rlen = $urandom_range(8);
            end
            3: begin
               slen = $urandom_range(9, 15);
               rlen = $urandom_range(9, 15);
            end
            default: begin
               slen = $urandom_range(1, 8);
               rlen = $urandom_range(0, 8);
            end
         endcase
         program_settings(pattern, slen, {$urandom, $urandom}, rlen);
         slen_eff = (slen > MAX_SEARCH) ? MAX_SEARCH : slen;

         phase_items = 0;
         pressured   = 1'b0;
         while (phase_items < PHASE_ITEMS) begin
            stream.delete();
            noise  = ($urandom_range(9) == 0);
            chunks = $urandom_range(1, 6);
            for (int c = 0; c < chunks; c++) begin
               pick = $urandom_range(99);
               if (noise || slen_eff == 0) begin
                  stream.push_back($urandom_range(255));
               end else if (pick < 45) begin
                  for (int i = 0; i < slen_eff; i++) stream.push_back(pattern[8*i +: 8]);
               end else if (pick < 65) begin
                  prefix = $urandom_range(1, slen_eff);
                  for (int i = 0; i < prefix; i++) stream.push_back(pattern[8*i +: 8]);
               end else if (pick < 82) begin
                  stream.push_back(alpha[$urandom_range(3)]);
               end else begin
                  stream.push_back($urandom_range(255));
               end
            end
            foreach (stream[i]) send_byte(stream[i], i == stream.size() - 1);
            phase_items += stream.size();
            if (!pressured && phase_items >= PHASE_ITEMS / 2) begin
               drain();
               pressured = 1'b1;
            end
         end
         // leave a partial stream in the window across the register change
         if ($urandom_range(1) == 1) begin
            repeat ($urandom_range(1, 4)) begin
               send_byte(alpha[$urandom_range(3)], 1'b0);
               phase_items++;
            end
         end
         drain();
         random_sent = items_sent - directed_items;
         phase++;
      end

      $display("covered %0d input bytes, %0d results, %0d register writes over %0d phases",
               items_sent, sb.checked_count, csr_writes, phase + 5);
      $display("saw %0d pattern matches, %0d mismatches", sb.match_count, sb.error_count);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("[streaming_substring_replace_unit] OK");
      end else begin
         $display("[streaming_substring_replace_unit] ERROR");
      end
      $finish;
   end

endmodule
